// ----- rtl/core/shlp_pkg.sv -----
// Shared types and constants for the spatial hash table with linear probing.
// Depends on nothing; imported by the hash unit and the top level.
`timescale 1ns / 1ps

package shlp_pkg;

	localparam logic [31:0] HASH_MUL_X = 32'd73856093;
	localparam logic [31:0] HASH_MUL_Z = 32'd19349663;

	localparam int KEY_W   = 16;
	localparam int IDX_W   = 8;
	localparam int USE_W   = 9;
	localparam int ENTRY_W = 1 + 2 * KEY_W;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_SPARE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_FOUND    = 3'd0,
		ST_INSERTED = 3'd1,
		ST_ABSENT   = 3'd2,
		ST_FULL     = 3'd3,
		ST_CLEARED  = 3'd4
	} status_t;

	typedef struct packed {
		logic             used;
		logic [KEY_W-1:0] kx;
		logic [KEY_W-1:0] kz;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_HASH  = 4'b0010,
		S_CHECK = 4'b0100,
		S_SWEEP = 4'b1000
	} state_t;

endpackage

// ----- rtl/core/shlp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module shlp_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/shlp_hash.sv -----
// Home-slot hash unit: two registered 32-bit products, xor, then reduction
// modulo the slot count (mask for a power of two, else reciprocal multiply).
// Depends on shlp_pkg.
`timescale 1ns / 1ps

module shlp_hash #(
	parameter int TABLE_SLOTS = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [shlp_pkg::KEY_W-1:0]     kx,
	input  logic [shlp_pkg::KEY_W-1:0]     kz,
	output logic                           done,
	output logic [$clog2(TABLE_SLOTS)-1:0] home
);

	import shlp_pkg::*;

	localparam int  AW      = $clog2(TABLE_SLOTS);
	localparam bit  IS_POW2 = (TABLE_SLOTS == (1 << AW));
	// ceil(2^(32+AW) / slots) gives an exact quotient for any 32-bit value
	localparam int  SH      = 32 + AW;
	localparam logic [63:0] RECIP_W =
		((64'd1 << SH) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
	localparam logic [32:0] RECIP = RECIP_W[32:0];
	localparam logic [31:0] MODV  = 32'(TABLE_SLOTS);

	logic          valid_s1;
	logic [31:0]   prod_x_s1;
	logic [31:0]   prod_z_s1;
	logic [31:0]   hv;
	logic          valid_s2;
	logic [31:0]   hv_s2;
	logic [64:0]   qprod_s2;
	logic [64:0]   qshift;
	logic [31:0]   quot;
	logic [31:0]   qm;
	logic [31:0]   rem;
	logic          done_q;
	logic [AW-1:0] home_q;

	assign hv = prod_x_s1 ^ prod_z_s1;

	// quotient by reciprocal, remainder by back-multiply and subtract
	assign qshift = qprod_s2 >> SH;
	assign quot   = qshift[31:0];
	assign qm     = quot * MODV;
	assign rem    = hv_s2 - qm;

	always_ff @(posedge clk) begin
		if (start) begin
			prod_x_s1 <= {{(32-KEY_W){kx[KEY_W-1]}}, kx} * HASH_MUL_X;
			prod_z_s1 <= {{(32-KEY_W){kz[KEY_W-1]}}, kz} * HASH_MUL_Z;
		end
		if (valid_s1) begin
			hv_s2    <= hv;
			qprod_s2 <= {33'd0, hv} * {32'd0, RECIP};
		end
		if (IS_POW2 && valid_s1) begin
			home_q <= hv[AW-1:0];
		end else if (!IS_POW2 && valid_s2) begin
			home_q <= rem[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1 && !IS_POW2;
			done_q   <= IS_POW2 ? valid_s1 : valid_s2;
		end
	end

	assign done = done_q;
	assign home = home_q;

endmodule

// ----- rtl/core/spatial_hash_linear_probe_table.sv -----
// Top level of the spatial hash table with linear probing.
// Depends on shlp_pkg, shlp_hash and shlp_ram.
`timescale 1ns / 1ps

// Open-addressing hash table keyed by a signed (x, z) grid coordinate. A
// transaction is taken when start is high and busy is low; its single result
// appears on status/slot_index/entries_in_use for exactly one cycle with done
// high, and there is no way to hold it off, so capture it on that cycle.
// With a power-of-two TABLE_SLOTS a lookup or insert first passes the
// registered hash multiply and reduction, then one probe per cycle comes out
// of the single-port-read slot RAM; it probes one slot when the key sits in
// its home slot and up to TABLE_SLOTS slots on a full table. For any other
// slot count the home slot is reduced by a reciprocal multiply, which adds a
// registered product ahead of the home slot register.
// A clear walks the RAM one slot per cycle and then reports with done.
// After reset the same clearing pass runs with busy high before the first
// transaction is accepted. busy drops on the cycle done is shown, so a new
// transaction may start then.
module spatial_hash_linear_probe_table #(
	parameter int TABLE_SLOTS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    op,
	input  logic signed [15:0]            key_x,
	input  logic signed [15:0]            key_z,
	output logic                          done,
	output logic [2:0]                    status,
	output logic [shlp_pkg::IDX_W-1:0]    slot_index,
	output logic [shlp_pkg::USE_W-1:0]    entries_in_use
);

	import shlp_pkg::*;

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam logic [AW-1:0] LAST = AW'(TABLE_SLOTS - 1);

	state_t        state_q;
	op_t           op_q;
	logic [15:0]   kx_q;
	logic [15:0]   kz_q;
	logic [AW-1:0] slot_q;
	logic [AW-1:0] probe_q;
	logic [AW-1:0] sweep_q;
	logic          clr_q;
	logic [CW-1:0] count_q;
	logic          done_q;
	status_t       status_q;
	logic [AW-1:0] index_q;

	logic          accept;
	logic          hash_start;
	logic          hash_done;
	logic [AW-1:0] hash_home;
	logic [AW-1:0] slot_nxt;
	logic          re;
	logic [AW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	entry_t        wdata;
	entry_t        rdata;
	logic          hit;
	logic          create;

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign hash_start = accept && (op_t'(op) != OP_CLEAR);
	assign create     = (op_q == OP_INSERT);

	shlp_hash #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.kx     (key_x),
		.kz     (key_z),
		.done   (hash_done),
		.home   (hash_home)
	);

	shlp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// next probe position, wrapping at the end of the table
	assign slot_nxt = (slot_q == LAST) ? '0 : slot_q + AW'(1);
	assign hit      = rdata.used && (rdata.kx == kx_q) && (rdata.kz == kz_q);

	// RAM port control. A write only ends a probe walk or belongs to a sweep;
	// the next read comes only after a new key has passed the hash, so no forwarding needed.
	always_comb begin
		re    = 1'b0;
		raddr = slot_nxt;
		we    = 1'b0;
		waddr = sweep_q;
		wdata = '0;
		case (state_q)
			S_HASH: begin
				re    = hash_done;
				raddr = hash_home;
			end
			S_CHECK: begin
				if (rdata.used && !hit) begin
					re = (probe_q != LAST);
				end else if (!rdata.used && create) begin
					we    = 1'b1;
					waddr = slot_q;
					wdata = '{used: 1'b1, kx: kx_q, kz: kz_q};
				end
			end
			S_SWEEP: begin
				we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_t'(op);
			kx_q <= key_x;
			kz_q <= key_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_SWEEP;
			sweep_q  <= '0;
			clr_q    <= 1'b0;
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_ABSENT;
			index_q  <= '0;
			slot_q   <= '0;
			probe_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (op_t'(op) == OP_CLEAR) begin
							state_q <= S_SWEEP;
							sweep_q <= '0;
							clr_q   <= 1'b1;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					if (hash_done) begin
						slot_q  <= hash_home;
						probe_q <= '0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (hit) begin
						done_q   <= 1'b1;
						status_q <= ST_FOUND;
						index_q  <= slot_q;
						state_q  <= S_IDLE;
					end else if (!rdata.used) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (create) begin
							status_q <= ST_INSERTED;
							index_q  <= slot_q;
							count_q  <= count_q + CW'(1);
						end else begin
							status_q <= ST_ABSENT;
							index_q  <= '0;
						end
					end else if (probe_q == LAST) begin
						// whole table walked without a match or a free slot
						done_q   <= 1'b1;
						status_q <= create ? ST_FULL : ST_ABSENT;
						index_q  <= '0;
						state_q  <= S_IDLE;
					end else begin
						slot_q  <= slot_nxt;
						probe_q <= probe_q + AW'(1);
					end
				end
				S_SWEEP: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == LAST) begin
						state_q <= S_IDLE;
						clr_q   <= 1'b0;
						if (clr_q) begin
							done_q   <= 1'b1;
							status_q <= ST_CLEARED;
							index_q  <= '0;
							count_q  <= '0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	logic [AW+IDX_W-1:0] index_ext;
	logic [CW+USE_W-1:0] count_ext;

	assign index_ext      = {{IDX_W{1'b0}}, index_q};
	assign count_ext      = {{USE_W{1'b0}}, count_q};
	assign done           = done_q;
	assign status         = status_q;
	assign slot_index     = index_ext[IDX_W-1:0];
	assign entries_in_use = count_ext[USE_W-1:0];

	// results only come out of a probe step or the end of a sweep
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_CHECK || $past(state_q) == S_SWEEP))
		else $error("result strobe without a probe or sweep");

	a_we_src: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_CHECK || state_q == S_SWEEP))
		else $error("slot write outside probe or sweep");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_SLOTS))
		else $error("entry count above slot count");

	a_insert_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q == ST_INSERTED) |-> (count_q == $past(count_q) + CW'(1)))
		else $error("insert without count increment");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transaction did not raise busy");

endmodule
